// File: sv/stdec_pkg.sv
`timescale 1ns / 1ps

package stdec_pkg;

   // Field widths of the request and response beats.
   localparam int unsigned OPCODE_W = 2;
   localparam int unsigned ADDR_W   = 11;
   localparam int unsigned DATA_W   = 16;
   localparam int unsigned TEXEL_W  = 32;
   localparam int unsigned PADDR_W  = 5;
   localparam int unsigned PDATA_W  = 32;

   // Default color RAM depth in 16-bit words.
   localparam int unsigned CRAM_WORDS_DEF = 2048;

   // Width of a color RAM word address before it wraps at the RAM size.
   localparam int unsigned X_W = 18;

   // Request opcodes.
   localparam logic [OPCODE_W-1:0] OP_CRAM_WR = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_LUT_WR  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_DECODE  = 2'd2;

   // Pixel modes.
   localparam logic [2:0] MODE_BANK4  = 3'd0;
   localparam logic [2:0] MODE_TABLE4 = 3'd1;
   localparam logic [2:0] MODE_BANK6  = 3'd2;
   localparam logic [2:0] MODE_BANK7  = 3'd3;
   localparam logic [2:0] MODE_BANK8  = 3'd4;
   localparam logic [2:0] MODE_DIRECT = 3'd5;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_PIXEL_MODE   = 3'd0;
   localparam logic [2:0] REG_BLEND_SELECT = 3'd1;
   localparam logic [2:0] REG_TRANSP_OFF   = 3'd2;
   localparam logic [2:0] REG_COLOR_BANK   = 3'd3;
   localparam logic [2:0] REG_CRAM_FORMAT  = 3'd4;
   localparam logic [2:0] REG_CRAM_OFFSET  = 3'd5;

   // Color RAM formats with special handling.
   localparam logic [1:0] FMT_WIDE = 2'd2;
   localparam logic [1:0] FMT_NONE = 2'd3;

   // Blend code that selects half alpha.
   localparam logic [2:0] BLEND_HALF = 3'd3;
   localparam logic [7:0] ALPHA_HALF = 8'h80;
   localparam logic [7:0] ALPHA_FULL = 8'hFF;

   // Color bank masks per bank mode.
   localparam logic [15:0] MASK_BANK4 = 16'hFFF0;
   localparam logic [15:0] MASK_BANK6 = 16'hFFC0;
   localparam logic [15:0] MASK_BANK7 = 16'hFF80;
   localparam logic [15:0] MASK_BANK8 = 16'hFF00;

   // Bank offset scale: 0x100 words for 16-bit colors, 0x200 for 32-bit.
   localparam int unsigned OFS_SHIFT_NARROW = 8;
   localparam int unsigned OFS_SHIFT_WIDE   = 9;

   // Kind of work a pipeline slot carries.
   typedef enum logic [1:0] {
      KIND_CRAM_WR,
      KIND_LUT_WR,
      KIND_TEXEL
   } kind_type;

   // Where the final texel color comes from.
   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_DIRECT,
      SRC_CRAM16,
      SRC_CRAM32
   } src_type;

   // Expand a 15-bit RGB word to a 32-bit texel.
   function automatic logic [TEXEL_W-1:0] rgb555(input logic [7:0] alpha,
                                                  input logic [15:0] c);
      return {alpha, c[14:10], 3'b000, c[9:5], 3'b000, c[4:0], 3'b000};
   endfunction

endpackage

// File: sv/stdec_if.sv
`timescale 1ns / 1ps

// Request channel: one beat carries a write or a source word to decode.
interface stdec_req_if;
   import stdec_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [ADDR_W-1:0]   address;
   logic [DATA_W-1:0]   data;

   modport source (output valid, output opcode, output address, output data,
                   input ready);
   modport sink   (input valid, input opcode, input address, input data,
                   output ready);
endinterface

// Response channel: one beat carries one texel.
interface stdec_rsp_if;
   import stdec_pkg::*;

   logic               valid;
   logic               ready;
   logic [TEXEL_W-1:0] texel;
   logic               last;

   modport source (output valid, output texel, output last, input ready);
   modport sink   (input valid, input texel, input last, output ready);
endinterface

// File: sv/sprite_texel_decoder.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// req_bus   in         valid / ready             opcode, address, data
// rsp_bus   out        valid / ready             texel, last
// config    in         psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// One request beat enters per cycle while the pipeline does not stall. Writes
// and decodes that give one texel leave at one beat per cycle when not stalled;
// four-bit modes give two texels per source byte, so such a beat holds the
// split stage until both texels have moved on. A texel then passes the decode
// stage, the color RAM address wrap (two multiplier stages, a subtraction and
// a correction), the registered color RAM read and the output register.
// Synchronous reset clears the valid bits and configuration registers; the
// color RAM and lookup table hold nothing defined until written.
// Every stage after the split stage stalls only when its successor is full and
// stalled, so bubbles close up before back-pressure reaches the request side.

module sprite_texel_decoder #(
   parameter int unsigned CRAM_WORDS = stdec_pkg::CRAM_WORDS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   stdec_req_if.sink                        req_bus,
   stdec_rsp_if.source                      rsp_bus,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [stdec_pkg::PADDR_W-1:0]    paddr,
   input  logic [stdec_pkg::PDATA_W-1:0]    pwdata,
   output logic [stdec_pkg::PDATA_W-1:0]    prdata,
   output logic                             pready
);
   import stdec_pkg::*;

   localparam int unsigned AW  = $clog2(CRAM_WORDS);
   localparam int unsigned MW  = X_W - $clog2(CRAM_WORDS) + 1;
   localparam int unsigned PW  = X_W + MW;
   localparam logic [MW-1:0]  RECIP_K = MW'((2 ** X_W) / CRAM_WORDS);
   localparam logic [X_W-1:0] SIZE_K  = X_W'(CRAM_WORDS);
   localparam logic [AW-1:0]  TOP_K   = AW'(CRAM_WORDS - 1);

   // Fields that travel with a slot after the split stage.
   typedef struct packed {
      kind_type          kind;
      logic              last;
      src_type           src;
      logic [DATA_W-1:0] color;
   } item_type;

   // Configuration registers.
   logic [2:0]  pixel_mode_ff;
   logic [2:0]  blend_select_ff;
   logic        transparent_off_ff;
   logic [15:0] color_bank_ff;
   logic [1:0]  cram_format_ff;
   logic [2:0]  cram_offset_ff;
   logic [2:0]  reg_index;
   logic        cfg_write;

   // Split stage.
   logic                s0_valid_ff;
   logic [OPCODE_W-1:0] s0_op_ff;
   logic [ADDR_W-1:0]   s0_addr_ff;
   logic [DATA_W-1:0]   s0_data_ff;
   logic                s0_phase_ff;
   logic                s0_phase_in;
   logic                job_has;
   logic                job_two;
   logic                job_last;
   kind_type            job_kind;
   logic [3:0]          job_nib;
   logic [7:0]          job_dot;
   logic                s0_done;
   logic                s0_ready;

   // Decode stage.
   logic              s1_valid_ff;
   kind_type          s1_kind_ff;
   logic              s1_last_ff;
   logic [7:0]        s1_dot_ff;
   logic [DATA_W-1:0] s1_word_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [DATA_W-1:0] lut_ff [16];
   logic [15:0]       bank_mask;
   logic [15:0]       bank_index;
   logic              dot_clear;
   logic              word_clear;
   item_type          s2_item_in;
   logic [X_W-1:0]    s2_x_in;
   logic              s1_ready;

   // Address wrap stages.
   logic           s2_valid_ff;
   item_type       s2_item_ff;
   logic [X_W-1:0] s2_x_ff;
   logic [PW-1:0]  recip_prod;
   logic [MW-1:0]  s3_q_in;
   logic           s2_ready;

   logic           s3_valid_ff;
   item_type       s3_item_ff;
   logic [X_W-1:0] s3_x_ff;
   logic [MW-1:0]  s3_q_ff;
   logic [PW-1:0]  q_prod;
   logic [X_W-1:0] s4_qc_in;
   logic           s3_ready;

   logic           s4_valid_ff;
   item_type       s4_item_ff;
   logic [X_W-1:0] s4_x_ff;
   logic [X_W-1:0] s4_qc_ff;
   logic [X_W-1:0] s5_d0_in;
   logic [X_W:0]   s5_d1_in;
   logic           s4_ready;

   logic           s5_valid_ff;
   item_type       s5_item_ff;
   logic [X_W-1:0] s5_d0_ff;
   logic [X_W:0]   s5_d1_ff;
   logic [X_W-1:0] mod_full;
   logic [AW-1:0]  s6_a0_in;
   logic [AW-1:0]  s6_a1_in;
   logic           s5_ready;

   // Color RAM access stage.
   logic              s6_valid_ff;
   item_type          s6_item_ff;
   logic [AW-1:0]     s6_a0_ff;
   logic [AW-1:0]     s6_a1_ff;
   logic              ram_wr_en;
   logic [DATA_W-1:0] ram_data_a;
   logic [DATA_W-1:0] ram_data_b;
   logic              s6_ready;

   // Color assembly and output register.
   logic               s7_valid_ff;
   item_type           s7_item_ff;
   logic [7:0]         alpha;
   logic [TEXEL_W-1:0] texel_in;
   logic               s7_ready;

   logic               rsp_valid_ff;
   logic [TEXEL_W-1:0] rsp_texel_ff;
   logic               rsp_last_ff;
   logic               s8_ready;

   // ---------------------------------------------------------------
   // Configuration port.
   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_mode_ff      <= '0;
         blend_select_ff    <= '0;
         transparent_off_ff <= 1'b0;
         color_bank_ff      <= '0;
         cram_format_ff     <= '0;
         cram_offset_ff     <= '0;
      end else if (cfg_write) begin
         unique case (reg_index)
            REG_PIXEL_MODE:   pixel_mode_ff      <= pwdata[2:0];
            REG_BLEND_SELECT: blend_select_ff    <= pwdata[2:0];
            REG_TRANSP_OFF:   transparent_off_ff <= pwdata[0];
            REG_COLOR_BANK:   color_bank_ff      <= pwdata[15:0];
            REG_CRAM_FORMAT:  cram_format_ff     <= pwdata[1:0];
            REG_CRAM_OFFSET:  cram_offset_ff     <= pwdata[2:0];
            default: ;
         endcase
      end
   end

   // Register readback.
   always_comb begin
      unique case (reg_index)
         REG_PIXEL_MODE:   prdata = PDATA_W'(pixel_mode_ff);
         REG_BLEND_SELECT: prdata = PDATA_W'(blend_select_ff);
         REG_TRANSP_OFF:   prdata = PDATA_W'(transparent_off_ff);
         REG_COLOR_BANK:   prdata = PDATA_W'(color_bank_ff);
         REG_CRAM_FORMAT:  prdata = PDATA_W'(cram_format_ff);
         REG_CRAM_OFFSET:  prdata = PDATA_W'(cram_offset_ff);
         default:          prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Ready chain: a stage can load when it is empty or its slot moves on.
   assign s8_ready = !rsp_valid_ff || rsp_bus.ready;
   assign s7_ready = !s7_valid_ff || s8_ready;
   assign s6_ready = !s6_valid_ff || s7_ready;
   assign s5_ready = !s5_valid_ff || s6_ready;
   assign s4_ready = !s4_valid_ff || s5_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;

   // ---------------------------------------------------------------
   // Split stage: turn a request beat into zero, one or two jobs.
   always_comb begin
      job_has  = 1'b0;
      job_two  = 1'b0;
      job_kind = KIND_TEXEL;
      unique case (s0_op_ff)
         OP_CRAM_WR: begin
            job_has  = 1'b1;
            job_kind = KIND_CRAM_WR;
         end
         OP_LUT_WR: begin
            job_has  = 1'b1;
            job_kind = KIND_LUT_WR;
         end
         OP_DECODE: begin
            case (pixel_mode_ff) inside
               MODE_BANK4, MODE_TABLE4: begin
                  job_has = 1'b1;
                  job_two = 1'b1;
               end
               MODE_BANK6, MODE_BANK7, MODE_BANK8, MODE_DIRECT: begin
                  job_has = 1'b1;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // High nibble goes first in the four-bit modes.
   assign job_last = !job_two || s0_phase_ff;
   assign job_nib  = s0_phase_ff ? s0_data_ff[3:0] : s0_data_ff[7:4];

   always_comb begin
      case (pixel_mode_ff) inside
         MODE_BANK4, MODE_TABLE4: job_dot = {4'b0000, job_nib};
         MODE_BANK6:              job_dot = {2'b00, s0_data_ff[5:0]};
         MODE_BANK7:              job_dot = {1'b0, s0_data_ff[6:0]};
         default:                 job_dot = s0_data_ff[7:0];
      endcase
   end

   assign s0_done  = s0_valid_ff && (!job_has || (s1_ready && job_last));
   assign s0_ready = !s0_valid_ff || s0_done;
   assign req_bus.ready = s0_ready;

   always_comb begin
      s0_phase_in = s0_phase_ff;
      if (s0_done) begin
         s0_phase_in = 1'b0;
      end else if (s0_valid_ff && job_has && s1_ready) begin
         s0_phase_in = 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Decode stage: transparency, lookup table, color RAM word address.
   always_comb begin
      case (pixel_mode_ff)
         MODE_BANK4: bank_mask = MASK_BANK4;
         MODE_BANK6: bank_mask = MASK_BANK6;
         MODE_BANK7: bank_mask = MASK_BANK7;
         default:    bank_mask = MASK_BANK8;
      endcase
   end

   assign bank_index = {8'h00, s1_dot_ff} + (color_bank_ff & bank_mask);
   assign dot_clear  = (s1_dot_ff == 8'h00) && !transparent_off_ff;
   assign word_clear = (s1_word_ff == '0) && !transparent_off_ff;

   always_comb begin
      s2_item_in.kind  = s1_kind_ff;
      s2_item_in.last  = s1_last_ff;
      s2_item_in.src   = SRC_ZERO;
      s2_item_in.color = s1_word_ff;
      if (cram_format_ff == FMT_WIDE) begin
         s2_x_in = (X_W'(bank_index) << 1) + (X_W'(cram_offset_ff) << OFS_SHIFT_WIDE);
      end else begin
         s2_x_in = X_W'(bank_index) + (X_W'(cram_offset_ff) << OFS_SHIFT_NARROW);
      end
      if (s1_kind_ff == KIND_CRAM_WR) begin
         s2_x_in = X_W'(s1_addr_ff);
      end else if (s1_kind_ff == KIND_TEXEL) begin
         case (pixel_mode_ff)
            MODE_TABLE4: begin
               s2_item_in.src   = dot_clear ? SRC_ZERO : SRC_DIRECT;
               s2_item_in.color = lut_ff[s1_dot_ff[3:0]];
            end
            MODE_DIRECT: begin
               s2_item_in.src = word_clear ? SRC_ZERO : SRC_DIRECT;
            end
            default: begin
               if (dot_clear) begin
                  s2_item_in.src = SRC_ZERO;
               end else begin
                  case (cram_format_ff)
                     FMT_WIDE: s2_item_in.src = SRC_CRAM32;
                     FMT_NONE: s2_item_in.src = SRC_ZERO;
                     default:  s2_item_in.src = SRC_CRAM16;
                  endcase
               end
            end
         endcase
      end
   end

   // Lookup table writes land as the write slot leaves the decode stage.
   always_ff @(posedge clock) begin
      if (s1_valid_ff && (s1_kind_ff == KIND_LUT_WR) && s2_ready) begin
         lut_ff[s1_addr_ff[3:0]] <= s1_word_ff;
      end
   end

   // ---------------------------------------------------------------
   // Wrap the word address at the RAM size: estimate the quotient by a
   // reciprocal, subtract, then correct by at most one RAM size.
   assign recip_prod = PW'(s2_x_ff) * PW'(RECIP_K);
   assign s3_q_in    = recip_prod[PW-1:X_W];

   assign q_prod   = PW'(s3_q_ff) * PW'(SIZE_K);
   assign s4_qc_in = q_prod[X_W-1:0];

   assign s5_d0_in = s4_x_ff - s4_qc_ff;
   assign s5_d1_in = {1'b0, s4_x_ff} - {1'b0, s4_qc_ff} - {1'b0, SIZE_K};

   assign mod_full = s5_d1_ff[X_W] ? s5_d0_ff : s5_d1_ff[X_W-1:0];
   assign s6_a0_in = mod_full[AW-1:0];
   assign s6_a1_in = (s6_a0_in == TOP_K) ? '0 : s6_a0_in + 1'b1;

   // ---------------------------------------------------------------
   // Color RAM: writes and reads both happen as a slot leaves stage six.
   assign ram_wr_en = s6_valid_ff && (s6_item_ff.kind == KIND_CRAM_WR) && s7_ready;

   stdec_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CRAM_WORDS)
   ) u_cram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (s6_a0_ff),
      .wr_data   (s6_item_ff.color),
      .rd_en     (s7_ready),
      .rd_addr_a (s6_a0_ff),
      .rd_addr_b (s6_a1_ff),
      .rd_data_a (ram_data_a),
      .rd_data_b (ram_data_b)
   );

   // ---------------------------------------------------------------
   // Texel assembly.
   assign alpha = (blend_select_ff == BLEND_HALF) ? ALPHA_HALF : ALPHA_FULL;

   always_comb begin
      unique case (s7_item_ff.src)
         SRC_ZERO:   texel_in = '0;
         SRC_DIRECT: texel_in = rgb555(alpha, s7_item_ff.color);
         SRC_CRAM16: texel_in = rgb555(alpha, ram_data_a);
         SRC_CRAM32: texel_in = {alpha, ram_data_a[7:0], ram_data_b};
         default:    texel_in = '0;
      endcase
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.texel = rsp_texel_ff;
   assign rsp_bus.last  = rsp_last_ff;

   // ---------------------------------------------------------------
   // Valid bits and split phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s0_phase_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_phase_ff <= s0_phase_in;
         if (s0_ready) begin
            s0_valid_ff <= req_bus.valid;
         end
         if (s1_ready) begin
            s1_valid_ff <= s0_valid_ff && job_has;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff && (s1_kind_ff != KIND_LUT_WR);
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (s5_ready) begin
            s5_valid_ff <= s4_valid_ff;
         end
         if (s6_ready) begin
            s6_valid_ff <= s5_valid_ff;
         end
         if (s7_ready) begin
            s7_valid_ff <= s6_valid_ff && (s6_item_ff.kind == KIND_TEXEL);
         end
         if (s8_ready) begin
            rsp_valid_ff <= s7_valid_ff;
         end
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (s0_ready && req_bus.valid) begin
         s0_op_ff   <= req_bus.opcode;
         s0_addr_ff <= req_bus.address;
         s0_data_ff <= req_bus.data;
      end
      if (s1_ready) begin
         s1_kind_ff <= job_kind;
         s1_last_ff <= job_last;
         s1_dot_ff  <= job_dot;
         s1_word_ff <= s0_data_ff;
         s1_addr_ff <= s0_addr_ff;
      end
      if (s2_ready) begin
         s2_item_ff <= s2_item_in;
         s2_x_ff    <= s2_x_in;
      end
      if (s3_ready) begin
         s3_item_ff <= s2_item_ff;
         s3_x_ff    <= s2_x_ff;
         s3_q_ff    <= s3_q_in;
      end
      if (s4_ready) begin
         s4_item_ff <= s3_item_ff;
         s4_x_ff    <= s3_x_ff;
         s4_qc_ff   <= s4_qc_in;
      end
      if (s5_ready) begin
         s5_item_ff <= s4_item_ff;
         s5_d0_ff   <= s5_d0_in;
         s5_d1_ff   <= s5_d1_in;
      end
      if (s6_ready) begin
         s6_item_ff <= s5_item_ff;
         s6_a0_ff   <= s6_a0_in;
         s6_a1_ff   <= s6_a1_in;
      end
      if (s7_ready) begin
         s7_item_ff <= s6_item_ff;
      end
      if (s8_ready) begin
         rsp_texel_ff <= texel_in;
         rsp_last_ff  <= s7_item_ff.last;
      end
   end

`ifndef SYNTHESIS
   // The wrapped address is always inside the color RAM.
   assert property (@(posedge clock) disable iff (reset)
      s5_valid_ff |-> (mod_full < SIZE_K))
      else $error("color RAM address wrap out of range");

   // Only the four-bit modes give a texel that is not the last of its beat.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.last) |->
         (pixel_mode_ff == MODE_BANK4 || pixel_mode_ff == MODE_TABLE4))
      else $error("first-half texel outside a four-bit mode");

   // The second half of a split is pending only while its beat is held.
   assert property (@(posedge clock) disable iff (reset)
      s0_phase_ff |-> s0_valid_ff)
      else $error("split phase set with no beat held");

   // Write slots never reach texel assembly.
   assert property (@(posedge clock) disable iff (reset)
      s7_valid_ff |-> (s7_item_ff.kind == KIND_TEXEL))
      else $error("write slot reached texel assembly");
`endif

endmodule

// File: sv/stdec_ram.sv
`timescale 1ns / 1ps

// Single write port, two registered read ports.
module stdec_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered reads; data holds while the read is not enabled.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
